// ----- rtl/core/cbcs_pkg.sv -----
// shared types, constants and the square-root step for the bezier connector sampler
`timescale 1ns / 1ps
package cbcs_pkg;

   localparam int CoordW = 20;
   localparam int CtrlW = 27;
   localparam int KW = 25;
   localparam int NW = 6;
   localparam int TW = 16;
   localparam int QW = 17;
   localparam int RadW = 53;
   localparam int RootW = 54;
   localparam int ReqW = 80;
   localparam int RspW = 48;

   localparam logic [NW-1:0] MaxSegments = 6'd63;
   localparam logic [3:0] SqrtCycles = 4'd14;
   localparam logic [4:0] DivCycles = 5'd17;
   localparam logic [15:0] TensionReset = 16'd1434;
   localparam logic [15:0] DensityReset = 16'd1966;

   localparam logic CsrTension = 1'b0;
   localparam logic CsrDensity = 1'b1;

   typedef struct packed {
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic signed [CtrlW-1:0] c1x;
      logic signed [CtrlW-1:0] c2x;
   } coord_type;

   typedef struct packed {
      coord_type c;
      logic [NW-1:0] n;
      logic [QW-1:0] q;
      logic [NW-1:0] r;
   } job_type;

   typedef struct packed {
      coord_type c;
      logic [TW-1:0] t;
      logic [NW-1:0] idx;
      logic last;
   } pt_type;

   typedef struct packed {
      coord_type c;
      logic [NW-1:0] idx;
      logic last;
   } meta_type;

   typedef struct packed {
      logic [RadW-1:0] v;
      logic [RootW-1:0] root;
      logic [RootW-1:0] pos;
   } sqrt_type;

   // one digit of the bit-pair integer square root
   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type o;
      logic [RootW-1:0] sum;
      o = s;
      sum = s.root + s.pos;
      if (s.pos != '0) begin
         if ({1'b0, s.v} >= sum) begin
            o.v = s.v - sum[RadW-1:0];
            o.root = (s.root >> 1) + s.pos;
         end else begin
            o.root = s.root >> 1;
         end
         o.pos = s.pos >> 2;
      end
      return o;
   endfunction

endpackage

// ----- rtl/core/cbcs_setup.sv -----
// per-request setup: distances, control points, segment count and step size
`timescale 1ns / 1ps
module cbcs_setup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cbcs_pkg::ReqW-1:0]     req_tdata,  // start_x, start_y, end_x, end_y
   input  logic [15:0]                   tension,
   input  logic [15:0]                   density,
   output logic                          job_valid,
   input  logic                          job_ready,
   output cbcs_pkg::job_type             job
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIFF  = 4'd1;
   localparam logic [3:0] ST_SQR   = 4'd2;
   localparam logic [3:0] ST_LOAD1 = 4'd3;
   localparam logic [3:0] ST_ROOT1 = 4'd4;
   localparam logic [3:0] ST_KMUL  = 4'd5;
   localparam logic [3:0] ST_KRND  = 4'd6;
   localparam logic [3:0] ST_MID   = 4'd7;
   localparam logic [3:0] ST_MSQ   = 4'd8;
   localparam logic [3:0] ST_LOAD2 = 4'd9;
   localparam logic [3:0] ST_ROOT2 = 4'd10;
   localparam logic [3:0] ST_LEN   = 4'd11;
   localparam logic [3:0] ST_NMUL  = 4'd12;
   localparam logic [3:0] ST_NSAT  = 4'd13;
   localparam logic [3:0] ST_DIV   = 4'd14;
   localparam logic [3:0] ST_HAND  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   logic signed [19:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [19:0] adx_ff, ady_ff;
   logic [39:0] sqx_ff, sqy_ff;
   cbcs_pkg::sqrt_type sq_ff;
   logic [40:0] prod_ff;
   logic [24:0] k_ff;
   logic [25:0] adx2_ff;
   logic [51:0] mid_ff;
   logic [27:0] len_ff;
   logic [5:0] n_ff;
   logic [16:0] dnum_ff;
   logic [6:0] drem_ff;

   logic signed [20:0] dx, dy;
   logic signed [27:0] dx2;
   logic [25:0] km16, akm;
   logic [28:0] lenr;
   logic [24:0] whole, nfull;
   logic [6:0] rem_sh;
   logic qbit;
   logic [6:0] rem_new;

   always_comb begin
      dx = {ex_ff[19], ex_ff} - {sx_ff[19], sx_ff};
      dy = {ey_ff[19], ey_ff} - {sy_ff[19], sy_ff};
      dx2 = {{8{ex_ff[19]}}, ex_ff} - {{8{sx_ff[19]}}, sx_ff} + 28'sd16
            - $signed({2'b00, k_ff, 1'b0});
      km16 = {1'b0, k_ff} - 26'd16;
      akm = km16[25] ? (26'd0 - km16) : km16;
      lenr = {1'b0, len_ff} + 29'd15;
      whole = lenr[28:4];
      nfull = prod_ff[40:16];
      rem_sh = {drem_ff[5:0], dnum_ff[16]};
      qbit = (rem_sh >= {1'b0, n_ff});
      rem_new = qbit ? (rem_sh - {1'b0, n_ff}) : rem_sh;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_SQR;
         ST_SQR:   state_in = ST_LOAD1;
         ST_LOAD1: begin
            state_in = ST_ROOT1;
            cnt_in = {1'b0, cbcs_pkg::SqrtCycles};
         end
         ST_ROOT1: begin
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_KMUL;
         end
         ST_KMUL:  state_in = ST_KRND;
         ST_KRND:  state_in = ST_MID;
         ST_MID:   state_in = ST_MSQ;
         ST_MSQ:   state_in = ST_LOAD2;
         ST_LOAD2: begin
            state_in = ST_ROOT2;
            cnt_in = {1'b0, cbcs_pkg::SqrtCycles};
         end
         ST_ROOT2: begin
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_LEN;
         end
         ST_LEN:   state_in = ST_NMUL;
         ST_NMUL:  state_in = ST_NSAT;
         ST_NSAT: begin
            cnt_in = cbcs_pkg::DivCycles;
            if (nfull == 25'd0) state_in = ST_HAND;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_HAND;
         end
         ST_HAND:  if (job_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sx_ff <= req_tdata[19:0];
            sy_ff <= req_tdata[39:20];
            ex_ff <= req_tdata[59:40];
            ey_ff <= req_tdata[79:60];
         end
         ST_DIFF: begin
            adx_ff <= dx[20] ? 20'(-dx) : dx[19:0];
            ady_ff <= dy[20] ? 20'(-dy) : dy[19:0];
         end
         ST_SQR: begin
            sqx_ff <= adx_ff * adx_ff;
            sqy_ff <= ady_ff * ady_ff;
         end
         ST_LOAD1: begin
            sq_ff.v <= 53'(sqx_ff) + 53'(sqy_ff);
            sq_ff.root <= '0;
            sq_ff.pos <= 54'd1 << 52;
         end
         ST_ROOT1, ST_ROOT2: sq_ff <= cbcs_pkg::sqrt_step(cbcs_pkg::sqrt_step(sq_ff));
         ST_KMUL:  prod_ff <= {21'd0, tension} * {16'd0, sq_ff.root[20:0]};
         ST_KRND:  k_ff <= 25'((prod_ff[36:0] + 37'd2048) >> 12);
         ST_MID:   adx2_ff <= dx2[27] ? 26'(-dx2) : dx2[25:0];
         ST_MSQ:   mid_ff <= adx2_ff * adx2_ff;
         ST_LOAD2: begin
            sq_ff.v <= 53'(mid_ff) + 53'(sqy_ff);
            sq_ff.root <= '0;
            sq_ff.pos <= 54'd1 << 52;
         end
         ST_LEN:   len_ff <= 28'(k_ff) + 28'(akm) + 28'(sq_ff.root[26:0]);
         ST_NMUL:  prod_ff <= whole * density;
         ST_NSAT: begin
            n_ff <= (nfull > 25'(cbcs_pkg::MaxSegments)) ? cbcs_pkg::MaxSegments
                                                          : nfull[5:0];
            dnum_ff <= 17'h10000;
            drem_ff <= '0;
         end
         ST_DIV: begin
            dnum_ff <= {dnum_ff[15:0], qbit};
            drem_ff <= rem_new;
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign job_valid = (state_ff == ST_HAND);

   always_comb begin
      job.c.sx = sx_ff;
      job.c.sy = sy_ff;
      job.c.ex = ex_ff;
      job.c.ey = ey_ff;
      job.c.c1x = {{7{sx_ff[19]}}, sx_ff} + $signed({2'b00, k_ff});
      job.c.c2x = {{7{ex_ff[19]}}, ex_ff} + 27'sd16 - $signed({2'b00, k_ff});
      job.n = n_ff;
      job.q = dnum_ff;
      job.r = drem_ff[5:0];
   end

endmodule

// ----- rtl/core/cbcs_gen.sv -----
// point sequencer: walks t = i/n one point per cycle while advance is high and marks the end point
`timescale 1ns / 1ps
module cbcs_gen (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  cbcs_pkg::job_type   job,
   input  logic                advance,
   output logic                pt_valid,
   output cbcs_pkg::pt_type    pt
);

   logic busy_ff;
   cbcs_pkg::job_type job_ff;
   logic [5:0] i_ff;
   logic [16:0] t_ff;
   logic [5:0] r_ff;
   logic [6:0] rsum;
   logic is_last;

   assign is_last = (i_ff == job_ff.n);
   assign rsum = {1'b0, r_ff} + {1'b0, job_ff.r};
   assign job_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (!busy_ff) begin
         busy_ff <= job_valid;
      end else if (advance && is_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         job_ff <= job;
         i_ff <= '0;
         t_ff <= '0;
         r_ff <= '0;
      end else if (advance && !is_last) begin
         i_ff <= i_ff + 6'd1;
         // running remainder keeps t equal to floor(i * 65536 / n)
         if (rsum >= {1'b0, job_ff.n}) begin
            r_ff <= 6'(rsum - {1'b0, job_ff.n});
            t_ff <= t_ff + job_ff.q + 17'd1;
         end else begin
            r_ff <= rsum[5:0];
            t_ff <= t_ff + job_ff.q;
         end
      end
   end

   assign pt_valid = busy_ff;

   always_comb begin
      pt.c = job_ff.c;
      pt.t = t_ff[15:0];
      pt.idx = i_ff;
      pt.last = is_last;
   end

endmodule

// ----- rtl/core/cbcs_eval.sv -----
// bernstein weight and blend pipeline with the output register
`timescale 1ns / 1ps
module cbcs_eval (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pt_valid,
   input  cbcs_pkg::pt_type           pt,
   output logic                       advance,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [cbcs_pkg::RspW-1:0]  rsp_tdata,  // point_x, point_y, point_index, 2 zero bits
   output logic                       rsp_tlast
);

   logic [4:0] vld_ff;
   logic out_vld_ff;
   cbcs_pkg::meta_type meta_ff [5];

   logic [16:0] u;
   logic [15:0] t1_ff;
   logic [33:0] uu1_ff;
   logic [32:0] ut1_ff;
   logic [31:0] tt1_ff;
   logic [49:0] a1_ff;
   logic [48:0] a2_ff;
   logic [47:0] a3_ff;
   logic [32:0] w0_ff, w1_ff, w2_ff, w3_ff, w01_ff, w23_ff;
   logic signed [60:0] px0_ff, px1_ff, px2_ff, px3_ff, py0_ff, py1_ff;
   logic signed [63:0] ax_ff, ay_ff;
   logic [19:0] ox_ff, oy_ff;
   logic [5:0] oidx_ff;
   logic olast_ff;

   logic [51:0] a1x3, a2x3;
   logic [32:0] w1, w2, w3;
   logic [33:0] w0s;
   logic signed [31:0] vx, vy;
   logic [19:0] sxo, syo;

   function automatic logic [26:0] CtrlExt(logic [19:0] v);
      return {{7{v[19]}}, v};
   endfunction

   assign advance = !out_vld_ff || rsp_tready;
   assign u = 17'h10000 - {1'b0, pt.t};

   always_comb begin
      a1x3 = {2'b00, a1_ff} + {1'b0, a1_ff, 1'b0};
      a2x3 = {3'b000, a2_ff} + {2'b00, a2_ff, 1'b0};
      w1 = a1x3[48:16];
      w2 = a2x3[48:16];
      w3 = {1'b0, a3_ff[47:16]};
      w0s = (34'd1 << 32) - {1'b0, w1} - {1'b0, w2} - {1'b0, w3};
      vx = ax_ff[63:32];
      vy = ay_ff[63:32];
      if (vx < -32'sd524288) sxo = 20'h80000;
      else if (vx > 32'sd524287) sxo = 20'h7FFFF;
      else sxo = vx[19:0];
      if (vy < -32'sd524288) syo = 20'h80000;
      else if (vy > 32'sd524287) syo = 20'h7FFFF;
      else syo = vy[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= {vld_ff[3:0], pt_valid};
         out_vld_ff <= vld_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[0] <= '{c: pt.c, idx: pt.idx, last: pt.last};
         for (int s = 1; s < 5; s++) meta_ff[s] <= meta_ff[s-1];
         // stage 1: second-order products of t and 1 - t
         t1_ff <= pt.t;
         uu1_ff <= u * u;
         ut1_ff <= u * pt.t;
         tt1_ff <= pt.t * pt.t;
         // stage 2: third-order products
         a1_ff <= uu1_ff * t1_ff;
         a2_ff <= ut1_ff * t1_ff;
         a3_ff <= tt1_ff * t1_ff;
         // stage 3: weights that sum to exactly one
         w0_ff <= w0s[32:0];
         w1_ff <= w1;
         w2_ff <= w2;
         w3_ff <= w3;
         w01_ff <= w0s[32:0] + w1;
         w23_ff <= w2 + w3;
         // stage 4: weighted coordinates, y controls share the end rows
         px0_ff <= $signed({1'b0, w0_ff}) * $signed(CtrlExt(meta_ff[2].c.sx));
         px1_ff <= $signed({1'b0, w1_ff}) * meta_ff[2].c.c1x;
         px2_ff <= $signed({1'b0, w2_ff}) * meta_ff[2].c.c2x;
         px3_ff <= $signed({1'b0, w3_ff}) * $signed(CtrlExt(meta_ff[2].c.ex));
         py0_ff <= $signed({1'b0, w01_ff}) * $signed(CtrlExt(meta_ff[2].c.sy));
         py1_ff <= $signed({1'b0, w23_ff}) * $signed(CtrlExt(meta_ff[2].c.ey));
         // stage 5: sums with half-unit rounding
         ax_ff <= 64'(px0_ff) + 64'(px1_ff) + 64'(px2_ff) + 64'(px3_ff)
                  + 64'sh80000000;
         ay_ff <= 64'(py0_ff) + 64'(py1_ff) + 64'sh80000000;
         // output: saturate, end point passes through exactly
         ox_ff <= meta_ff[4].last ? meta_ff[4].c.ex : sxo;
         oy_ff <= meta_ff[4].last ? meta_ff[4].c.ey : syo;
         oidx_ff <= meta_ff[4].idx;
         olast_ff <= meta_ff[4].last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {2'b00, oidx_ff, oy_ff, ox_ff};
   assign rsp_tlast = olast_ff;

endmodule

// ----- rtl/core/cubic_bezier_connector_sampler.sv -----
// top level of the cubic bezier connector sampler
`timescale 1ns / 1ps
// Samples a horizontal-tangent cubic bezier between a start and an end point.
// req channel: one word per curve, start_x/start_y/end_x/end_y in signed Q16.4.
// rsp channel: n + 1 words per curve, the points at t = i/n for i below n and
// then the exact end point with rsp_tlast high; point_index counts from zero.
// n comes from the control-polygon length times segment_density, at most 63;
// with n = 0 only the end point is sent.
// csr port: index 0 is tension (Q4.12), index 1 is segment_density (Q0.16);
// write them only while no curve is in flight.
// Setup runs two square roots (two root bits a cycle) and a divide for the t
// step of each curve. Setup of the next curve overlaps the point stream of
// the current one. Points of a curve leave at one per cycle while rsp_tready
// is high; once its setup ends, the first point passes through the sequencer,
// the evaluation stages and the output register.
// Reset clears every valid flag and loads the default register values.
// A stall on rsp_tready freezes the whole point pipeline; nothing is dropped.
module cubic_bezier_connector_sampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cbcs_pkg::ReqW-1:0]     req_tdata,  // start_x, start_y, end_x, end_y
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cbcs_pkg::RspW-1:0]     rsp_tdata,  // point_x, point_y, point_index, pad
   output logic                          rsp_tlast,
   input  logic                          csr_wen,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_wdata
);

   logic [15:0] tension_ff, density_ff;
   logic job_valid, job_ready, pt_valid, advance;
   cbcs_pkg::job_type job;
   cbcs_pkg::pt_type pt;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= cbcs_pkg::TensionReset;
         density_ff <= cbcs_pkg::DensityReset;
      end else if (csr_wen) begin
         if (csr_index == cbcs_pkg::CsrTension) tension_ff <= csr_wdata;
         if (csr_index == cbcs_pkg::CsrDensity) density_ff <= csr_wdata;
      end
   end

   cbcs_setup u_setup (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .tension(tension_ff), .density(density_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   cbcs_gen u_gen (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .advance(advance), .pt_valid(pt_valid), .pt(pt)
   );

   cbcs_eval u_eval (
      .clock(clock), .reset(reset),
      .pt_valid(pt_valid), .pt(pt), .advance(advance),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

`ifndef SYNTHESIS
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid && $stable(job))
      else $error("setup job changed before the sequencer took it");

   a_first_t: assert property (@(posedge clock) disable iff (reset)
      pt_valid && pt.idx == 6'd0 |-> pt.t == 16'd0)
      else $error("first point of a run does not start at t = 0");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ----- verif/tb_top.sv -----
// testbench for the cubic bezier connector sampler: directed and random curves against a point predictor
`timescale 1ns / 1ps

typedef struct {
   logic signed [19:0] x;
   logic signed [19:0] y;
   logic [5:0]         idx;
   logic               last;
} curve_point_type;

class curve_scoreboard;
   curve_point_type   pending[$];
   longint unsigned   tension;
   longint unsigned   density;
   int                errors;

   function new();
      tension = cbcs_pkg::TensionReset;
      density = cbcs_pkg::DensityReset;
      errors = 0;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned span(longint dx, longint dy);
      longint unsigned ax, ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      return root_floor(ax * ax + ay * ay);
   endfunction

   function automatic logic signed [19:0] clamp20(longint v);
      if (v < -524288) return -20'sd524288;
      if (v > 524287) return 20'sd524287;
      return v[19:0];
   endfunction

   // expand one accepted curve into its expected point stream
   function void note_curve(logic signed [19:0] sx20, logic signed [19:0] sy20,
                            logic signed [19:0] ex20, logic signed [19:0] ey20);
      longint sx, sy, ex, ey, k, c1x, c2x, w0, w1, w2, w3, ax, ay;
      longint unsigned d, len, whole, n, t, u;
      curve_point_type p;
      sx = sx20; sy = sy20; ex = ex20; ey = ey20;
      d = span(ex - sx, ey - sy);
      k = longint'((tension * d + 2048) >> 12);
      c1x = sx + k;
      c2x = ex + 16 - k;
      len = span(k, 0) + span(c2x - c1x, ey - sy) + span(ex - c2x, 0);
      whole = (len + 15) >> 4;
      n = (whole * density) >> 16;
      if (n > 63) n = 63;
      for (longint unsigned i = 0; i < n; i++) begin
         t = (i << 16) / n;
         u = 65536 - t;
         w1 = longint'((3 * u * u * t) >> 16);
         w2 = longint'((3 * u * t * t) >> 16);
         w3 = longint'((t * t * t) >> 16);
         w0 = (64'sd1 <<< 32) - w1 - w2 - w3;
         ax = w0 * sx + w1 * c1x + w2 * c2x + w3 * ex;
         ay = w0 * sy + w1 * sy + w2 * ey + w3 * ey;
         p.x = clamp20((ax + (64'sd1 <<< 31)) >>> 32);
         p.y = clamp20((ay + (64'sd1 <<< 31)) >>> 32);
         p.idx = i[5:0];
         p.last = 1'b0;
         pending.push_back(p);
      end
      p.x = ex20; p.y = ey20; p.idx = n[5:0]; p.last = 1'b1;
      pending.push_back(p);
   endfunction

   function void check_point(logic [19:0] x, logic [19:0] y, logic [5:0] idx, logic last);
      curve_point_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected point x=%0d y=%0d idx=%0d last=%0b", $time,
                  $signed(x), $signed(y), idx, last);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.idx !== idx || e.last !== last) begin
         $display("%0t: point mismatch expected x=%0d y=%0d idx=%0d last=%0b", $time,
                  e.x, e.y, e.idx, e.last);
         $display("%0t:                actual   x=%0d y=%0d idx=%0d last=%0b", $time,
                  $signed(x), $signed(y), idx, last);
         errors++;
      end
   endfunction
endclass

module tb_top;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [cbcs_pkg::ReqW-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [cbcs_pkg::RspW-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_wen = 1'b0;
   logic                      csr_index = cbcs_pkg::CsrTension;
   logic [15:0]               csr_wdata = '0;

   curve_scoreboard sb = new();
   int              curves_sent = 0;
   int              hold_left = 0;
   bit              long_hold_done = 0;

   always #2 clock = ~clock;

   cubic_bezier_connector_sampler dut (.*);

   // point receiver with random back-pressure and one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_point(rsp_tdata[19:0], rsp_tdata[39:20], rsp_tdata[45:40], rsp_tlast);
         if (!long_hold_done && curves_sent >= 60) begin
            long_hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 4) begin
            hold_left = $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 75) || (curves_sent % 50 < 10);
         end
      end
   end

   task automatic write_csr(logic idx, logic [15:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == cbcs_pkg::CsrTension) sb.tension = value;
      else sb.density = value;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_curve(logic [19:0] sx, logic [19:0] sy, logic [19:0] ex, logic [19:0] ey);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      sb.note_curve(sx, sy, ex, ey);
      curves_sent++;
      gap = ($urandom_range(0, 99) < 40) ? 0 :
            ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(20, 120);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [19:0] sx, sy, ex, ey;
      int mode;
      mode = $urandom_range(0, 9);
      sx = $urandom; sy = $urandom;
      if (mode < 6) begin
         // nearby end point: short curves with few segments
         ex = sx + 20'($signed($urandom_range(0, 8000)) - 4000);
         ey = sy + 20'($signed($urandom_range(0, 8000)) - 4000);
      end else if (mode < 8) begin
         ex = $urandom; ey = $urandom;
      end else begin
         ex = sx + 20'($urandom_range(0, 40));
         ey = sy;
      end
      send_curve(sx, sy, ex, ey);
   endtask

   initial begin
      logic [15:0] tens[5] = '{16'd1434, 16'd0, 16'd65535, 16'd4096, 16'd700};
      logic [15:0] dens[5] = '{16'd1966, 16'd65535, 16'd0, 16'd300, 16'd12000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, extreme and saturating curves
      send_curve(20'd0, 20'd0, 20'd0, 20'd0);
      send_curve(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF);
      send_curve(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000);
      send_curve(20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000);
      send_curve(20'd100, 20'd50, 20'd4100, 20'd50);
      send_curve(20'h12345, 20'hABCDE, 20'h12345, 20'hABCDE);
      drain();
      write_csr(cbcs_pkg::CsrDensity, 16'd65535);
      send_curve(20'd0, 20'd0, 20'd160, 20'd0);
      send_curve(20'd16, 20'hFFFF0, 20'hFFF00, 20'd320);
      drain();
      write_csr(cbcs_pkg::CsrTension, 16'd65535);
      send_curve(20'h80000, 20'd0, 20'h7FFFF, 20'd0);
      send_curve(20'h7FFF0, 20'd5, 20'h7FFFF, 20'd5);
      send_curve(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF);
      drain();
      write_csr(cbcs_pkg::CsrTension, 16'd0);
      write_csr(cbcs_pkg::CsrDensity, 16'd0);
      send_curve(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(cbcs_pkg::CsrTension, tens[ph]);
         write_csr(cbcs_pkg::CsrDensity, dens[ph]);
         for (int i = 0; i < 54; i++) begin
            send_random();
            // sender waits for the full drain once, midway through phase 1
            if (ph == 1 && i == 20) begin
               req_tvalid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
